[rtl/eorp_pkg.sv]
// Shared constants and types of the elevation outlier row patcher.
// No dependencies; imported by elevation_outlier_row_patcher_unit.
package eorp_pkg;

    // Grid geometry
    localparam int MAX_COLS = 4096;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int LEN_W    = COL_W + 1;
    localparam int ROW_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_W  = ((ROW_W + COL_W + SAMPLE_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - (ROW_W + COL_W + SAMPLE_W);

    // Register reset values
    localparam logic [LEN_W-1:0]    ROW_LENGTH_RST  = LEN_W'(3601);
    localparam logic [SAMPLE_W-1:0] UPPER_LIMIT_RST = SAMPLE_W'(5000);
    localparam logic [ROW_W-1:0]    ROW_TOP         = {ROW_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 1'b1;

    // Item held in the read-modify-write stage
    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [SAMPLE_W-1:0] sample;
    } stage_word_t;

    // Result word held in the output register
    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [SAMPLE_W-1:0] elevation;
        logic                replaced;
        logic                last;
    } result_word_t;

endpackage

[rtl/elevation_outlier_row_patcher_unit.sv]
// Top level of the elevation outlier row patcher: position tracking,
// line memory read-modify-write and output register. Uses eorp_pkg.
//
// Usage: samples enter in raster order on the s_axis channel, one word per
// sample (tuser marks the first sample of a grid). Results leave on the
// m_axis channel with their row and column. Row 0 is held in the line
// memory and gives no result; each row-1 sample gives two words (the row-0
// sample of that column, then the row-1 sample); later rows give one.
// A sample's word goes from the memory stage into the output register; the
// second word of a row-1 sample follows the first. Throughput: one sample
// per cycle while m_axis_tready is high; a row-1 sample holds the memory
// stage until both its words are emitted, since the single output register
// delivers one word a cycle. The line memory is read when a sample is
// accepted and written back when the item finishes in the memory stage; a
// write-to-read bypass covers two samples in a row on the same column (row
// length one, or a start mark right after column 0).
// Reset: position goes to row 0, column 0, registers to their defaults,
// the output register empties. The line memory is not cleared.
// Stall: while m_axis_tready is low the output register holds its word,
// one sample waits in the memory stage and s_axis_tready drops; row-0
// samples still pass, since they give no word. Configuration is written
// by the user via cfg_wr_en/cfg_index/cfg_wdata while idle; unenforced.
module elevation_outlier_row_patcher_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample_value
    input  logic [15:0]                         s_axis_tdata,
    // start_of_image
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row_index [15:0], column_index [27:16], elevation [43:28], zero pad
    output logic [eorp_pkg::TDATA_W-1:0]        m_axis_tdata,
    // was_replaced
    output logic                                m_axis_tuser,
    // last_of_run
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [eorp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [eorp_pkg::CFG_W-1:0]          cfg_wdata
);
    import eorp_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]    row_length_reg;
    logic [SAMPLE_W-1:0] upper_limit_reg;

    // Position
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [LEN_W-1:0] eff_len;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;

    // Memory stage
    logic [SAMPLE_W-1:0] line_mem [MAX_COLS];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                s1_valid_reg;
    stage_word_t         s1_reg;
    logic                phase_reg;
    logic                byp_reg;
    logic [SAMPLE_W-1:0] byp_data_reg;

    // Output register
    logic         m_valid_reg;
    result_word_t m_word_reg;

    // Stage logic
    logic                s_accept, out_free, emit, s1_done;
    logic                row_is0, row_is1;
    logic [SAMPLE_W-1:0] above, patched_above, new_val, wr_data;
    logic                rep_s, rep_above;
    result_word_t        res_word;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg  <= ROW_LENGTH_RST;
            upper_limit_reg <= UPPER_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROW_LENGTH:  row_length_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_UPPER_LIMIT: upper_limit_reg <= cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Position of the incoming sample and the one after it
    always_comb begin
        if (row_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (row_length_reg > LEN_W'(MAX_COLS)) begin
            eff_len = LEN_W'(MAX_COLS);
        end else begin
            eff_len = row_length_reg;
        end
        cur_col = s_axis_tuser ? '0 : col_pos_reg;
        cur_row = s_axis_tuser ? '0 : row_pos_reg;
        if ({1'b0, cur_col} >= eff_len) begin
            cur_col = '0;
        end
        if (({1'b0, cur_col} + LEN_W'(1)) >= eff_len) begin
            col_pos_next = '0;
            row_pos_next = (cur_row == ROW_TOP) ? cur_row : cur_row + ROW_W'(1);
        end else begin
            col_pos_next = cur_col + COL_W'(1);
            row_pos_next = cur_row;
        end
    end

    // Correction of the item in the memory stage
    always_comb begin
        row_is0       = (s1_reg.row == '0);
        row_is1       = (s1_reg.row == ROW_W'(1));
        above         = byp_reg ? byp_data_reg : rd_data_reg;
        rep_s         = s1_reg.sample > upper_limit_reg;
        rep_above     = above > upper_limit_reg;
        patched_above = rep_above ? s1_reg.sample : above;
        if (row_is1) begin
            new_val = rep_s ? patched_above : s1_reg.sample;
        end else begin
            new_val = rep_s ? above : s1_reg.sample;
        end
        wr_data = row_is0 ? s1_reg.sample : new_val;
        if (row_is1 && !phase_reg) begin
            res_word = '{row: '0, col: s1_reg.col, elevation: patched_above,
                         replaced: rep_above, last: 1'b0};
        end else begin
            res_word = '{row: s1_reg.row, col: s1_reg.col, elevation: new_val,
                         replaced: rep_s, last: 1'b1};
        end
    end

    // Handshake between stages
    always_comb begin
        out_free      = !m_valid_reg || m_axis_tready;
        emit          = s1_valid_reg && !row_is0 && out_free;
        s1_done       = s1_valid_reg && (row_is0 || (out_free && (!row_is1 || phase_reg)));
        s_axis_tready = !s1_valid_reg || s1_done;
        s_accept      = s_axis_tvalid && s_axis_tready;
    end

    // Line memory: read on accept, write back when the item finishes
    always_ff @(posedge aclk) begin
        if (s1_done) begin
            line_mem[s1_reg.col] <= wr_data;
        end
        if (s_accept) begin
            rd_data_reg <= line_mem[cur_col];
        end
    end

    // Memory stage registers and bypass of a same-column write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            byp_reg      <= 1'b0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= s1_done && (s1_reg.col == cur_col);
                col_pos_reg  <= col_pos_next;
                row_pos_reg  <= row_pos_next;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
                byp_reg      <= 1'b0;
            end
            if (s1_done) begin
                phase_reg <= 1'b0;
            end else if (emit && row_is1) begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg       <= '{row: cur_row, col: cur_col, sample: s_axis_tdata};
            byp_data_reg <= wr_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_word_reg <= res_word;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_word_reg.elevation, m_word_reg.col,
                            m_word_reg.row};
    assign m_axis_tuser  = m_word_reg.replaced;
    assign m_axis_tlast  = m_word_reg.last;

    // Checks
    a_phase_row1: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (s1_valid_reg && row_is1))
        else $error("second result phase without a row-1 item");

    a_first_is_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_word_reg.last) |-> (m_word_reg.row == '0))
        else $error("non-final result that is not a row-0 sample");

    a_byp_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_reg |-> s1_valid_reg)
        else $error("bypass set without an item in the memory stage");

    a_row0_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && row_is0) |=> !$rose(m_valid_reg) || $past(m_valid_reg))
        else $error("row-0 item produced a result");

endmodule
